// File: src/hsv2rgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB pixel pipeline.
// No dependencies.
package hsv2rgb_pkg;

   localparam logic [14:0] HueTurn   = 15'd23040;   // one full turn in 1/64 degree
   localparam logic [11:0] HueSector = 12'd3840;    // sixty degrees
   localparam logic [7:0]  FullScale = 8'd255;
   localparam logic [19:0] Denom     = 20'd979200;  // 255 * 3840
   // ceil(2^32 / 3825): exact quotient for dividends below 2^20
   localparam logic [20:0] RecipM    = 21'd1122868;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW   = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN   = 3'd2,
      SEC_CYAN_BLUE    = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED  = 3'd5
   } sector_type;

   // word handed from the sector splitter to the level pipeline
   typedef struct packed {
      sector_type  sector;
      logic [11:0] frac;
      logic [11:0] frac_c;   // 3840 - frac, 1..3840
      logic [7:0]  sat;
      logic [7:0]  val;
   } sector_word_type;

   // word handed from the level pipeline to the channel router
   typedef struct packed {
      sector_type sector;
      logic [7:0] val;
      logic [7:0] lvl_p;
      logic [7:0] lvl_q;
      logic [7:0] lvl_t;
   } level_word_type;

   function automatic logic [14:0] sector_base(input sector_type sec);
      logic [14:0] base;
      unique case (sec)
         SEC_RED_YELLOW:   base = 15'd0;
         SEC_YELLOW_GREEN: base = 15'd3840;
         SEC_GREEN_CYAN:   base = 15'd7680;
         SEC_CYAN_BLUE:    base = 15'd11520;
         SEC_BLUE_MAGENTA: base = 15'd15360;
         SEC_MAGENTA_RED:  base = 15'd19200;
         default:          base = 15'd0;
      endcase
      return base;
   endfunction

   // floor(x / 255), exact for any x below 65280
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      return sum[15:8];
   endfunction

endpackage

// File: src/hsv_to_rgb_pixel.sv
// Top level of the HSV to RGB pixel converter: sector split, level pipeline
// and channel routing. Depends on hsv2rgb_pkg, hsv2rgb_sector, hsv2rgb_levels.

// One pixel word is taken on every clock edge at which start is high; busy is
// never raised, so a new pixel may be offered in every cycle. Each pixel comes
// out on rsp_red/rsp_green/rsp_blue with rsp_strobe high for that single
// cycle, in the order the pixels went in. It passes through seven register
// stages: hue wrap and sector compare, sector fraction, saturation
// products, numerators and p, value products, reciprocal divide, and the
// routing register. The receiver cannot stall the pipeline and must take each
// word in the cycle it is shown. Hue of a full turn (23040) or more counts as
// zero; zero saturation gives grey at the given brightness.
module hsv_to_rgb_pixel (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [14:0] req_hue,
   input  logic [7:0]  req_saturation,
   input  logic [7:0]  req_brightness,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue
);

   logic                         sec_valid;
   hsv2rgb_pkg::sector_word_type sec_word;
   logic                         lvl_valid;
   hsv2rgb_pkg::level_word_type  lvl_word;

   logic       strobe_ff, strobe_in;
   logic [7:0] red_ff, red_in, green_ff, green_in, blue_ff, blue_in;

   assign busy = 1'b0;

   hsv2rgb_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start),
      .hue       (req_hue),
      .sat       (req_saturation),
      .val       (req_brightness),
      .out_valid (sec_valid),
      .out_word  (sec_word)
   );

   hsv2rgb_levels u_levels (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sec_valid),
      .in_word   (sec_word),
      .out_valid (lvl_valid),
      .out_word  (lvl_word)
   );

   always_comb begin
      strobe_in = lvl_valid;
      unique case (lvl_word.sector)
         hsv2rgb_pkg::SEC_RED_YELLOW: begin
            red_in = lvl_word.val;   green_in = lvl_word.lvl_t; blue_in = lvl_word.lvl_p;
         end
         hsv2rgb_pkg::SEC_YELLOW_GREEN: begin
            red_in = lvl_word.lvl_q; green_in = lvl_word.val;   blue_in = lvl_word.lvl_p;
         end
         hsv2rgb_pkg::SEC_GREEN_CYAN: begin
            red_in = lvl_word.lvl_p; green_in = lvl_word.val;   blue_in = lvl_word.lvl_t;
         end
         hsv2rgb_pkg::SEC_CYAN_BLUE: begin
            red_in = lvl_word.lvl_p; green_in = lvl_word.lvl_q; blue_in = lvl_word.val;
         end
         hsv2rgb_pkg::SEC_BLUE_MAGENTA: begin
            red_in = lvl_word.lvl_t; green_in = lvl_word.lvl_p; blue_in = lvl_word.val;
         end
         default: begin
            red_in = lvl_word.val;   green_in = lvl_word.lvl_p; blue_in = lvl_word.lvl_q;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_red    = red_ff;
   assign rsp_green  = green_ff;
   assign rsp_blue   = blue_ff;

   // every accepted word comes out on rsp_strobe
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##7 rsp_strobe)
      else $error("accepted word did not appear after seven cycles");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start, 7))
      else $error("result word without a matching request");

   // the brightest channel always equals the value
   a_max_is_value: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_red == $past(req_brightness, 7) ||
                      rsp_green == $past(req_brightness, 7) ||
                      rsp_blue == $past(req_brightness, 7)))
      else $error("no channel equals the brightness");

   a_grey: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(req_saturation, 7) == 8'd0) |->
         (rsp_red == $past(req_brightness, 7) &&
          rsp_green == $past(req_brightness, 7) &&
          rsp_blue == $past(req_brightness, 7)))
      else $error("zero saturation did not give grey");

endmodule

// File: src/hsv2rgb_sector.sv
// Hue wrap and sector split: two register stages producing sector and fraction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [14:0]                  hue,
   input  logic [7:0]                   sat,
   input  logic [7:0]                   val,
   output logic                         out_valid,
   output hsv2rgb_pkg::sector_word_type out_word
);

   logic                   s1_valid_ff, s1_valid_in;
   logic [14:0]            s1_hue_ff, s1_hue_in;
   hsv2rgb_pkg::sector_type s1_sector_ff, s1_sector_in;
   logic [7:0]             s1_sat_ff, s1_val_ff;

   logic                         s2_valid_ff;
   hsv2rgb_pkg::sector_word_type s2_word_ff, s2_word_in;
   logic [14:0]                  frac_wide;

   // stage 1: wrap and sector by threshold compare
   always_comb begin
      s1_valid_in  = in_valid;
      s1_hue_in    = hue;
      priority if (hue >= hsv2rgb_pkg::HueTurn) begin
         s1_hue_in    = 15'd0;
         s1_sector_in = hsv2rgb_pkg::SEC_RED_YELLOW;
      end else if (hue >= 15'd19200) begin
         s1_sector_in = hsv2rgb_pkg::SEC_MAGENTA_RED;
      end else if (hue >= 15'd15360) begin
         s1_sector_in = hsv2rgb_pkg::SEC_BLUE_MAGENTA;
      end else if (hue >= 15'd11520) begin
         s1_sector_in = hsv2rgb_pkg::SEC_CYAN_BLUE;
      end else if (hue >= 15'd7680) begin
         s1_sector_in = hsv2rgb_pkg::SEC_GREEN_CYAN;
      end else if (hue >= 15'd3840) begin
         s1_sector_in = hsv2rgb_pkg::SEC_YELLOW_GREEN;
      end else begin
         s1_sector_in = hsv2rgb_pkg::SEC_RED_YELLOW;
      end
   end

   // stage 2: fraction within the sector
   always_comb begin
      frac_wide          = s1_hue_ff - hsv2rgb_pkg::sector_base(s1_sector_ff);
      s2_word_in.sector  = s1_sector_ff;
      s2_word_in.frac    = frac_wide[11:0];
      s2_word_in.frac_c  = hsv2rgb_pkg::HueSector - frac_wide[11:0];
      s2_word_in.sat     = s1_sat_ff;
      s2_word_in.val     = s1_val_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_hue_ff    <= s1_hue_in;
      s1_sector_ff <= s1_sector_in;
      s1_sat_ff    <= sat;
      s1_val_ff    <= val;
      s2_word_ff   <= s2_word_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = s2_word_ff;

endmodule

// File: src/hsv2rgb_levels.sv
// Level pipeline: forms p, q and t over four register stages.
// Depends on hsv2rgb_pkg.
module hsv2rgb_levels (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  hsv2rgb_pkg::sector_word_type in_word,
   output logic                         out_valid,
   output hsv2rgb_pkg::level_word_type  out_word
);

   logic [3:0] valid_ff, valid_in;

   // stage 3: products with saturation
   hsv2rgb_pkg::sector_type s3_sector_ff;
   logic [7:0]  s3_val_ff;
   logic [19:0] s3_sf_ff, s3_sfc_ff, s3_sf_in, s3_sfc_in;
   logic [15:0] s3_pprod_ff, s3_pprod_in;

   // stage 4: numerators and p
   hsv2rgb_pkg::sector_type s4_sector_ff;
   logic [7:0]  s4_val_ff, s4_p_ff;
   logic [19:0] s4_nq_ff, s4_nt_ff;

   // stage 5: scaled by value
   hsv2rgb_pkg::sector_type s5_sector_ff;
   logic [7:0]  s5_val_ff, s5_p_ff;
   logic [27:0] s5_yq_ff, s5_yt_ff, s5_yq_in, s5_yt_in;

   // stage 6: divide by 979200 = 256 * 3825 via reciprocal
   hsv2rgb_pkg::level_word_type s6_word_ff;
   logic [40:0] quo_q, quo_t;

   assign valid_in = {valid_ff[2:0], in_valid};

   always_comb begin
      s3_sf_in    = 20'(in_word.sat) * 20'(in_word.frac);
      s3_sfc_in   = 20'(in_word.sat) * 20'(in_word.frac_c);
      s3_pprod_in = 16'(in_word.val) * 16'(hsv2rgb_pkg::FullScale - in_word.sat);
      s5_yq_in    = 28'(s4_val_ff) * 28'(s4_nq_ff);
      s5_yt_in    = 28'(s4_val_ff) * 28'(s4_nt_ff);
      quo_q       = 41'(s5_yq_ff[27:8]) * 41'(hsv2rgb_pkg::RecipM);
      quo_t       = 41'(s5_yt_ff[27:8]) * 41'(hsv2rgb_pkg::RecipM);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_sector_ff <= in_word.sector;
      s3_val_ff    <= in_word.val;
      s3_sf_ff     <= s3_sf_in;
      s3_sfc_ff    <= s3_sfc_in;
      s3_pprod_ff  <= s3_pprod_in;

      s4_sector_ff <= s3_sector_ff;
      s4_val_ff    <= s3_val_ff;
      s4_p_ff      <= hsv2rgb_pkg::div255(s3_pprod_ff);
      s4_nq_ff     <= hsv2rgb_pkg::Denom - s3_sf_ff;
      s4_nt_ff     <= hsv2rgb_pkg::Denom - s3_sfc_ff;

      s5_sector_ff <= s4_sector_ff;
      s5_val_ff    <= s4_val_ff;
      s5_p_ff      <= s4_p_ff;
      s5_yq_ff     <= s5_yq_in;
      s5_yt_ff     <= s5_yt_in;

      s6_word_ff.sector <= s5_sector_ff;
      s6_word_ff.val    <= s5_val_ff;
      s6_word_ff.lvl_p  <= s5_p_ff;
      s6_word_ff.lvl_q  <= quo_q[39:32];
      s6_word_ff.lvl_t  <= quo_t[39:32];
   end

   assign out_valid = valid_ff[3];
   assign out_word  = s6_word_ff;

endmodule

// File: tb/sv/hsv_to_rgb_pixel_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for hsv_to_rgb_pixel: directed and random pixels,
// each result checked against a hand-filled expectation or an in-bench HSV to RGB predictor.
// Depends on hsv2rgb_pkg and hsv_to_rgb_pixel.
module hsv_to_rgb_pixel_test;

   localparam int NumRandom   = 1650;
   localparam int NumDirected = 20;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 40;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_rgb_type;

   typedef struct packed {
      logic [14:0]   hue;
      logic [7:0]    sat;
      logic [7:0]    val;
      logic          typed;   // want below is filled in by hand
      pixel_rgb_type want;
   } hsv_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [14:0] req_hue;
   logic [7:0]  req_saturation;
   logic [7:0]  req_brightness;
   logic        rsp_strobe;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;

   pixel_rgb_type rgb_due[$];
   int            errors;
   int            words_taken;
   int            cycles;
   bit            idle_on;
   bit            cur_typed;
   pixel_rgb_type cur_want;

   hsv_row_type hsv_rows [NumDirected] = '{
      '{15'd0,     8'd0,   8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{15'd0,     8'd0,   8'd255, 1'b1, '{8'd255, 8'd255, 8'd255}},
      '{15'd12345, 8'd0,   8'd77,  1'b1, '{8'd77,  8'd77,  8'd77}},
      '{15'd0,     8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd3840,  8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd0}},
      '{15'd7680,  8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd0}},
      '{15'd11520, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd255, 8'd255}},
      '{15'd15360, 8'd255, 8'd255, 1'b1, '{8'd0,   8'd0,   8'd255}},
      '{15'd19200, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd255}},
      '{15'd23040, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd32767, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd23039, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd0,   8'd0}},
      '{15'd21000, 8'd255, 8'd0,   1'b1, '{8'd0,   8'd0,   8'd0}},
      '{15'd3839,  8'd255, 8'd255, 1'b0, '0},
      '{15'd1920,  8'd128, 8'd200, 1'b0, '0},
      '{15'd9600,  8'd200, 8'd100, 1'b0, '0},
      '{15'd17280, 8'd1,   8'd1,   1'b0, '0},
      '{15'd5000,  8'd254, 8'd254, 1'b0, '0},
      '{15'd13440, 8'd85,  8'd170, 1'b0, '0},
      '{15'd24000, 8'd100, 8'd50,  1'b0, '0}
   };

   hsv_to_rgb_pixel i_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_strobe     (rsp_strobe),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   // exact integer conversion, floors only
   function automatic pixel_rgb_type rgb_of_hsv(input logic [14:0] hue,
                                                input logic [7:0] sat,
                                                input logic [7:0] val);
      logic [14:0]             h;
      hsv2rgb_pkg::sector_type sec;
      logic [63:0]             vv, ss, ff, lp, lq, lt;
      pixel_rgb_type           c;
      h   = (hue >= hsv2rgb_pkg::HueTurn) ? 15'd0 : hue;
      sec = hsv2rgb_pkg::sector_type'(3'(h / hsv2rgb_pkg::HueSector));
      vv  = 64'(val);
      ss  = 64'(sat);
      ff  = 64'(h % hsv2rgb_pkg::HueSector);
      lp  = vv * (64'(hsv2rgb_pkg::FullScale) - ss) / 64'(hsv2rgb_pkg::FullScale);
      lq  = vv * (64'(hsv2rgb_pkg::Denom) - ss * ff) / 64'(hsv2rgb_pkg::Denom);
      lt  = vv * (64'(hsv2rgb_pkg::Denom) - ss * (64'(hsv2rgb_pkg::HueSector) - ff))
            / 64'(hsv2rgb_pkg::Denom);
      unique case (sec)
         hsv2rgb_pkg::SEC_RED_YELLOW:   c = '{val,      lt[7:0], lp[7:0]};
         hsv2rgb_pkg::SEC_YELLOW_GREEN: c = '{lq[7:0],  val,     lp[7:0]};
         hsv2rgb_pkg::SEC_GREEN_CYAN:   c = '{lp[7:0],  val,     lt[7:0]};
         hsv2rgb_pkg::SEC_CYAN_BLUE:    c = '{lp[7:0],  lq[7:0], val};
         hsv2rgb_pkg::SEC_BLUE_MAGENTA: c = '{lt[7:0],  lp[7:0], val};
         default:                       c = '{val,      lp[7:0], lq[7:0]};
      endcase
      return c;
   endfunction

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result check first, then record the word taken at this edge
   always @(posedge clock) begin
      pixel_rgb_type got, exp_rgb;
      if (!reset) begin
         if (rsp_strobe) begin
            got = '{rsp_red, rsp_green, rsp_blue};
            if (rgb_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel r=%0d g=%0d b=%0d",
                        $realtime, rsp_red, rsp_green, rsp_blue);
            end else begin
               exp_rgb = rgb_due.pop_front();
               if (got !== exp_rgb) begin
                  errors++;
                  $display("%0t: pixel mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                           $realtime, exp_rgb.red, exp_rgb.green, exp_rgb.blue,
                           got.red, got.green, got.blue);
               end
            end
         end
         if (start && !busy) begin
            rgb_due.push_back(cur_typed ? cur_want
                              : rgb_of_hsv(req_hue, req_saturation, req_brightness));
            words_taken++;
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_pixel(input logic [14:0] hue, input logic [7:0] sat,
                             input logic [7:0] val, input bit typed,
                             input pixel_rgb_type want);
      int taken0;
      while (idle_on && $urandom_range(0, 99) < 31) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= val;
      cur_typed = typed;
      cur_want  = want;
      taken0    = words_taken;
      @(negedge clock);
      while (words_taken == taken0)
         @(negedge clock);
   endtask

   initial begin
      logic [14:0] hue;
      logic [7:0]  sat, val;
      int          pick, n;
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      errors         = 0;
      words_taken    = 0;
      cycles         = 0;
      idle_on        = 1'b1;
      cur_typed      = 1'b0;
      cur_want       = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (hsv_rows[i])
         send_pixel(hsv_rows[i].hue, hsv_rows[i].sat, hsv_rows[i].val,
                    hsv_rows[i].typed, hsv_rows[i].want);

      for (int i = 0; i < NumRandom; i++) begin
         idle_on = !(i >= 600 && i < 900);
         if (i == 1100) begin
            // hold off until the pipeline has emptied
            start <= 1'b0;
            @(negedge clock);
            while (rgb_due.size() != 0)
               @(negedge clock);
         end
         pick = $urandom_range(0, 9);
         if (pick < 6)
            hue = 15'($urandom_range(0, 23039));
         else if (pick == 6)
            hue = 15'($urandom_range(1, 6) * 3840 + $urandom_range(0, 2) - 1);
         else if (pick == 7)
            hue = 15'($urandom_range(23040, 32767));
         else
            hue = 15'($urandom_range(0, 32767));
         pick = $urandom_range(0, 9);
         sat  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         pick = $urandom_range(0, 9);
         val  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : 8'($urandom_range(0, 255));
         send_pixel(hue, sat, val, 1'b0, '0);
      end
      start <= 1'b0;

      for (n = 0; n < 200 && rgb_due.size() != 0; n++)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (rgb_due.size() != 0) begin
         errors += rgb_due.size();
         $display("%0t: %0d pixels never came out", $realtime, rgb_due.size());
      end
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
